// ===== hdl/vector_polar_rect_converter_unit_macros.svh =====
// Assertion macros shared by checker files.
`ifndef VECTOR_POLAR_RECT_CONVERTER_UNIT_MACROS_SVH
`define VECTOR_POLAR_RECT_CONVERTER_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define VPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define VPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/vpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpr_pkg
// Types, constants and tables of the polar/rectangular vector unit.
// ----------------------------------------------------------------------------
package vpr_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int ANGLE_BITS        = 24;
    localparam int GUARD             = 8;
    localparam int CMD_WIDTH         = 3;
    localparam int STATUS_WIDTH      = 2;
    localparam longint INVK_Q30      = 64'sd652032874;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_RECT_TO_POLAR = 3'd0,
        CMD_POLAR_TO_RECT = 3'd1,
        CMD_ROTATE        = 3'd2,
        CMD_OPPOSITE      = 3'd3,
        CMD_ORTHOGONAL    = 3'd4,
        CMD_UNIT          = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    function automatic logic [31:0] atan_lookup(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
            12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
            18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
            21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
            24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
            27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/vpr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpr_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface vpr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/vector_polar_rect_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_polar_rect_converter_unit
// Rectangular/polar conversion, rotation, opposite, orthogonal and unit vectors on a CORDIC pipe.
// ----------------------------------------------------------------------------
// One item enters per clock while the pipe advances. The stages are: an input
// register ahead of the prescale multiply, a sign-fold stage, one register per
// vectoring and rotation iteration of the unrolled CORDIC, a hand-off stage
// between the two passes, and an output rounding/saturation stage.
// The whole pipe advances when the output register is empty or taken.
module vector_polar_rect_converter_unit #(
    parameter int COORD_WIDTH   = vpr_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS     = vpr_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = vpr_pkg::CORDIC_STAGES_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    vpr_stream_if.sink   in_ch,
    vpr_stream_if.source out_ch
);

    localparam int G  = vpr_pkg::GUARD;
    localparam int IW = COORD_WIDTH + G + 6;
    localparam int AB = vpr_pkg::ANGLE_BITS;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        sat;
        logic        zero;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic [COORD_WIDTH-1:0]        mag;
        logic [AB-1:0]                 ang;
    } tag_t;
    localparam int TW = $bits(tag_t);

    logic en;
    logic ov_reg;
    assign en = !ov_reg || out_ch.ready;
    assign in_ch.ready = en;

    localparam longint CHI = (64'sd1 <<< (COORD_WIDTH-1)) - 1;
    localparam longint CLO = -CHI - 1;
    localparam longint MHI = (64'sd1 <<< COORD_WIDTH) - 1;

    // stage 0: command decode, saturation, operand select
    logic [2:0] cmd;
    logic signed [24:0] f1;
    logic signed [23:0] f2;
    logic [23:0] da;
    logic signed [COORD_WIDTH+1:0] xs, ys, nx, ny;
    logic signed [COORD_WIDTH+1:0] xi, yi;
    logic sat_c, zero_c, vec_c, rot_c, unit_c;
    logic signed [COORD_WIDTH:0] m_c;
    logic [AB-1:0] a_c;
    tag_t t_c;
    logic signed [COORD_WIDTH+1:0] op_x, op_y;

    function automatic logic signed [COORD_WIDTH+1:0] satc(
        input logic signed [COORD_WIDTH+1:0] v, inout logic f);
        logic signed [COORD_WIDTH+1:0] r;
        r = v;
        if (v > (COORD_WIDTH+2)'(CHI)) begin f = 1'b1; r = (COORD_WIDTH+2)'(CHI); end
        else if (v < (COORD_WIDTH+2)'(CLO)) begin f = 1'b1; r = (COORD_WIDTH+2)'(CLO); end
        return r;
    endfunction

    always_comb
    begin
        cmd = in_ch.data[3+25+24+24-1 -: 3];
        f1  = in_ch.data[25+24+24-1 -: 25];
        f2  = in_ch.data[24+24-1 -: 24];
        da  = in_ch.data[23:0];
        sat_c = 1'b0;
        zero_c = 1'b0;
        vec_c = 1'b0;
        rot_c = 1'b0;
        unit_c = 1'b0;
        m_c = '0;
        a_c = '0;
        op_x = '0;
        op_y = '0;
        xs = satc((COORD_WIDTH+2)'($signed(f1[COORD_WIDTH:0])), sat_c);
        ys = (COORD_WIDTH+2)'($signed(f2[COORD_WIDTH-1:0]));
        xi = xs;
        yi = ys;
        nx = '0;
        ny = '0;
        case (cmd)
            vpr_pkg::CMD_POLAR_TO_RECT, vpr_pkg::CMD_ROTATE:
            begin
                sat_c = 1'b0;
                m_c = f1[COORD_WIDTH:0];
                if (m_c < 0)
                begin
                    m_c = '0;
                    sat_c = 1'b1;
                end
                a_c = f2;
                if (cmd == vpr_pkg::CMD_ROTATE)
                    a_c = f2 + da;
                op_x = (COORD_WIDTH+2)'(m_c);
                rot_c = 1'b1;
            end
            vpr_pkg::CMD_RECT_TO_POLAR, vpr_pkg::CMD_OPPOSITE,
            vpr_pkg::CMD_ORTHOGONAL, vpr_pkg::CMD_UNIT:
            begin
                if (cmd == vpr_pkg::CMD_OPPOSITE)
                begin
                    nx = -xs; ny = -ys;
                    xi = satc(nx, sat_c);
                    yi = satc(ny, sat_c);
                end
                else if (cmd == vpr_pkg::CMD_ORTHOGONAL)
                begin
                    nx = -ys; ny = xs;
                    xi = satc(nx, sat_c);
                    yi = satc(ny, sat_c);
                end
                zero_c = (xi == 0) && (yi == 0);
                op_x = xi;
                op_y = yi;
                vec_c = !zero_c;
                if (cmd == vpr_pkg::CMD_UNIT)
                begin
                    unit_c = !zero_c;
                    rot_c = !zero_c;
                end
            end
            default: sat_c = 1'b0;
        endcase
        t_c.cmd  = cmd;
        t_c.sat  = sat_c;
        t_c.zero = zero_c;
        t_c.px   = xi[COORD_WIDTH-1:0];
        t_c.py   = yi[COORD_WIDTH-1:0];
        t_c.mag  = m_c[COORD_WIDTH-1:0];
        t_c.ang  = a_c;
    end

    // stage 1: prescale multiply by 1/K
    logic v1_reg;
    tag_t t1_reg;
    logic vec1_reg, rot1_reg, unit1_reg;
    logic signed [COORD_WIDTH+1:0] ox1_reg, oy1_reg;
    logic [31:0] z1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= t_c;
            vec1_reg <= vec_c;
            rot1_reg <= rot_c;
            unit1_reg <= unit_c;
            ox1_reg  <= op_x;
            oy1_reg  <= op_y;
            z1_reg   <= {a_c, {(32-AB){1'b0}}};
        end
    end

    logic signed [COORD_WIDTH+33:0] px_w, py_w;
    logic signed [IW-1:0] pxs, pys;
    assign px_w = (ox1_reg * $signed(32'(vpr_pkg::INVK_Q30)))
                  + ((COORD_WIDTH+34)'(64'sd1) <<< (29 - G));
    assign py_w = (oy1_reg * $signed(32'(vpr_pkg::INVK_Q30)))
                  + ((COORD_WIDTH+34)'(64'sd1) <<< (29 - G));
    assign pxs = IW'(px_w >>> (30 - G));
    assign pys = IW'(py_w >>> (30 - G));

    logic cv;
    logic signed [IW-1:0] cx, cy;
    logic [31:0] cz, cvz;
    logic [TW-1:0] ctag;

    vpr_cordic #(
        .COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS),
        .CORDIC_STAGES(CORDIC_STAGES), .IW(IW), .TW(TW)
    ) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1_reg), .in_vec(vec1_reg), .in_rot(rot1_reg),
        .in_unit(unit1_reg), .in_x(pxs), .in_y(pys), .in_z(z1_reg),
        .in_tag(t1_reg),
        .out_valid(cv), .out_x(cx), .out_y(cy), .out_z(cz), .out_vz(cvz),
        .out_tag(ctag)
    );

    // output stage: unscale, round, saturate
    tag_t t_o;
    logic signed [IW-1:0] ux, uy;
    logic sat_o;
    logic signed [COORD_WIDTH+1:0] sx, sy;
    logic [COORD_WIDTH-1:0] rx, ry, rm;
    logic [AB-1:0] ra, ang_r;
    logic [1:0] rst_c;
    logic [31:0] zr;
    logic signed [IW-1:0] umag;

    always_comb
    begin
        t_o  = tag_t'(ctag);
        ux   = (cx + (IW'(1) <<< (G-1))) >>> G;
        uy   = (cy + (IW'(1) <<< (G-1))) >>> G;
        sat_o = t_o.sat;
        zr   = cvz + (32'd1 << (31 - AB));
        ang_r = zr[31 -: AB];
        rx = '0; ry = '0; rm = '0; ra = '0;
        sx = '0; sy = '0;
        umag = ux;
        rst_c = vpr_pkg::ST_OK;
        case (t_o.cmd)
            vpr_pkg::CMD_POLAR_TO_RECT, vpr_pkg::CMD_ROTATE, vpr_pkg::CMD_UNIT:
            begin
                if (t_o.cmd == vpr_pkg::CMD_UNIT && t_o.zero)
                    rst_c = vpr_pkg::ST_ZERO;
                else
                begin
                    sx = (ux > IW'(CHI)) ? (COORD_WIDTH+2)'(CHI) :
                         (ux < IW'(CLO)) ? (COORD_WIDTH+2)'(CLO) : (COORD_WIDTH+2)'(ux);
                    sy = (uy > IW'(CHI)) ? (COORD_WIDTH+2)'(CHI) :
                         (uy < IW'(CLO)) ? (COORD_WIDTH+2)'(CLO) : (COORD_WIDTH+2)'(uy);
                    if (ux > IW'(CHI) || ux < IW'(CLO) || uy > IW'(CHI) || uy < IW'(CLO))
                        sat_o = 1'b1;
                    rx = sx[COORD_WIDTH-1:0];
                    ry = sy[COORD_WIDTH-1:0];
                    if (t_o.cmd == vpr_pkg::CMD_UNIT)
                    begin
                        rm = (FRAC_BITS >= COORD_WIDTH) ? COORD_WIDTH'(MHI)
                             : COORD_WIDTH'(64'd1 << FRAC_BITS);
                        ra = ang_r;
                    end
                    else
                    begin
                        rm = t_o.mag;
                        ra = t_o.ang;
                    end
                end
            end
            vpr_pkg::CMD_RECT_TO_POLAR, vpr_pkg::CMD_OPPOSITE, vpr_pkg::CMD_ORTHOGONAL:
            begin
                rx = t_o.px;
                ry = t_o.py;
                if (!t_o.zero)
                begin
                    rm = (umag < 0) ? '0 : (umag > IW'(MHI)) ? COORD_WIDTH'(MHI)
                         : COORD_WIDTH'(umag);
                    ra = ang_r;
                end
            end
            default: ;
        endcase
        if (rst_c == vpr_pkg::ST_OK && sat_o)
            rst_c = vpr_pkg::ST_SAT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= cv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_ch.data <= {rx, ry, rm, ra, rst_c};
    end

    assign out_ch.valid = ov_reg;

endmodule

// ===== hdl/vpr_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpr_cordic
// Pipelined two-pass CORDIC: vectoring then rotation, one stage per register.
// ----------------------------------------------------------------------------
module vpr_cordic #(
    parameter int COORD_WIDTH   = vpr_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS     = vpr_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = vpr_pkg::CORDIC_STAGES_DEF,
    parameter int IW            = COORD_WIDTH + vpr_pkg::GUARD + 6,
    parameter int TW            = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  in_vec,
    input  logic                  in_rot,
    input  logic                  in_unit,
    input  logic signed [IW-1:0]  in_x,
    input  logic signed [IW-1:0]  in_y,
    input  logic [31:0]           in_z,
    input  logic [TW-1:0]         in_tag,
    output logic                  out_valid,
    output logic signed [IW-1:0]  out_x,
    output logic signed [IW-1:0]  out_y,
    output logic [31:0]           out_z,
    output logic [31:0]           out_vz,
    output logic [TW-1:0]         out_tag
);

    localparam int NS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int NP = 2 * NS + 2;

    typedef struct packed {
        logic             vec;
        logic             rot;
        logic             unit;
        logic [TW-1:0]    tag;
        logic [31:0]      vz;
    } ctl_t;

    logic                 v_reg [NP+1];
    ctl_t                 c_reg [NP+1];
    logic signed [IW-1:0] x_reg [NP+1];
    logic signed [IW-1:0] y_reg [NP+1];
    logic [31:0]          z_reg [NP+1];

    always_comb
    begin
        v_reg[0] = in_valid;
        c_reg[0] = '{vec: in_vec, rot: in_rot, unit: in_unit, tag: in_tag, vz: 32'd0};
        x_reg[0] = in_x;
        y_reg[0] = in_y;
        z_reg[0] = in_z;
    end

    localparam logic signed [IW-1:0] ONE_PRE =
        IW'((((64'sd1 << FRAC_BITS) * vpr_pkg::INVK_Q30)
             + (64'sd1 << (29 - vpr_pkg::GUARD))) >>> (30 - vpr_pkg::GUARD));

    genvar s;
    generate
        for (s = 0; s < NP; s++)
        begin : g_st
            logic signed [IW-1:0] x_next, y_next;
            logic [31:0]          z_next;
            ctl_t                 c_next;
            always_comb
            begin
                x_next = x_reg[s];
                y_next = y_reg[s];
                z_next = z_reg[s];
                c_next = c_reg[s];
                if (s == 0)
                begin
                    if (c_reg[s].vec && x_reg[s] < 0)
                    begin
                        x_next = -x_reg[s];
                        y_next = -y_reg[s];
                        z_next = 32'h80000000;
                    end
                    else if (c_reg[s].vec)
                        z_next = 32'd0;
                end
                else if (s <= NS)
                begin
                    if (c_reg[s].vec)
                    begin
                        if (y_reg[s] >= 0)
                        begin
                            x_next = x_reg[s] + (y_reg[s] >>> (s-1));
                            y_next = y_reg[s] - (x_reg[s] >>> (s-1));
                            z_next = z_reg[s] + vpr_pkg::atan_lookup(s-1);
                        end
                        else
                        begin
                            x_next = x_reg[s] - (y_reg[s] >>> (s-1));
                            y_next = y_reg[s] + (x_reg[s] >>> (s-1));
                            z_next = z_reg[s] - vpr_pkg::atan_lookup(s-1);
                        end
                    end
                end
                else if (s == NS + 1)
                begin
                    // hand vectoring angle to rotation for unit vectors
                    c_next.vz = z_reg[s];
                    if (c_reg[s].unit)
                    begin
                        x_next = ONE_PRE;
                        y_next = '0;
                        z_next = z_reg[s];
                    end
                    if (c_reg[s].rot)
                    begin
                        if (z_next[31:30] == 2'b01 || z_next[31:30] == 2'b10)
                        begin
                            x_next = -x_next;
                            z_next = z_next + 32'h80000000;
                        end
                    end
                end
                else
                begin
                    if (c_reg[s].rot)
                    begin
                        if (!z_reg[s][31])
                        begin
                            x_next = x_reg[s] - (y_reg[s] >>> (s-NS-2));
                            y_next = y_reg[s] + (x_reg[s] >>> (s-NS-2));
                            z_next = z_reg[s] - vpr_pkg::atan_lookup(s-NS-2);
                        end
                        else
                        begin
                            x_next = x_reg[s] + (y_reg[s] >>> (s-NS-2));
                            y_next = y_reg[s] - (x_reg[s] >>> (s-NS-2));
                            z_next = z_reg[s] + vpr_pkg::atan_lookup(s-NS-2);
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s+1] <= 1'b0;
                else if (en)
                    v_reg[s+1] <= v_reg[s];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_reg[s+1] <= c_next;
                    x_reg[s+1] <= x_next;
                    y_reg[s+1] <= y_next;
                    z_reg[s+1] <= z_next;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NP];
    assign out_x     = x_reg[NP];
    assign out_y     = y_reg[NP];
    assign out_z     = z_reg[NP];
    assign out_vz    = c_reg[NP].vz;
    assign out_tag   = c_reg[NP].tag;

endmodule

// ===== hdl/vpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpr_checker
// Port-level checks of the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector_polar_rect_converter_unit_macros.svh"
module vpr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [97:0] out_data
);
    `VPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `VPR_ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && !out_ready, $stable(out_data))
    `VPR_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready)
    `VPR_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_data[1:0] != 2'd3)
endmodule

bind vector_polar_rect_converter_unit vpr_checker u_vpr_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);

// ===== tb/vector_polar_rect_converter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_polar_rect_converter_unit_test
// Streams directed and random vector commands through the converter with
// random idling on both channels and one long output hold-off. Each result
// is compared field by field with a CORDIC predictor kept in this bench.
// ----------------------------------------------------------------------------
module vector_polar_rect_converter_unit_test;
    import vpr_pkg::*;

    typedef struct packed {
        cmd_t               command;
        logic signed [24:0] in_first;
        logic signed [23:0] in_second;
        logic signed [23:0] delta_angle;
    } vec_cmd_t;

    typedef struct packed {
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic [23:0]        out_magnitude;
        logic [23:0]        out_angle;
        status_t            status;
    } vec_res_t;

    localparam longint COORD_MAX = (64'sd1 <<< 23) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< 23);
    localparam longint MAG_MAX   = (64'sd1 <<< 24) - 1;
    localparam longint UNIT_ONE  = 64'sd1 <<< 16;
    localparam int     LATENCY   = 2 * CORDIC_STAGES_DEF + 5;
    localparam int     IDLE_LIMIT = 3000;
    localparam int     HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    vpr_stream_if #(.payload_t(vec_cmd_t)) in_ch ();
    vpr_stream_if #(.payload_t(vec_res_t)) out_ch ();

    vector_polar_rect_converter_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    vec_cmd_t pending_cmds[$];
    vec_res_t expected_results[$];
    int       in_transfers;
    int       issued;
    int       errors;
    int       send_gap;
    int       recv_gap;
    int       hold_count;
    bit       hold_done;
    int       idle_cycles;

    function automatic longint sat_coord(input longint v, inout bit flag);
        if (v > COORD_MAX) begin
            flag = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            flag = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    function automatic longint prescale_gain(input longint v);
        return (v * INVK_Q30 + (64'sd1 <<< (29 - GUARD))) >>> (30 - GUARD);
    endfunction

    function automatic longint drop_guard(input longint v);
        return (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    endfunction

    function automatic void cordic_vector(input longint x, input longint y,
                                          output longint mag, output logic [31:0] ang);
        longint vx, vy, dx, dy;
        logic [31:0] z;
        mag = 0;
        ang = '0;
        if (x == 0 && y == 0)
            return;
        vx = prescale_gain(x);
        vy = prescale_gain(y);
        z = '0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            z = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx += dx;
                vy -= dy;
                z += atan_lookup(i);
            end
            else
            begin
                vx -= dx;
                vy += dy;
                z -= atan_lookup(i);
            end
        end
        mag = drop_guard(vx);
        if (mag < 0)
            mag = 0;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        ang = z;
    endfunction

    function automatic void cordic_rotate(input longint m, input logic [31:0] z_in,
                                          output longint x, output longint y);
        longint vx, vy, dx, dy;
        logic [31:0] z;
        vx = prescale_gain(m);
        vy = 0;
        z = z_in;
        if (z[31:30] == 2'd1 || z[31:30] == 2'd2)
        begin
            vx = -vx;
            z += 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (!z[31])
            begin
                vx -= dx;
                vy += dy;
                z -= atan_lookup(i);
            end
            else
            begin
                vx += dx;
                vy -= dy;
                z += atan_lookup(i);
            end
        end
        x = drop_guard(vx);
        y = drop_guard(vy);
    endfunction

    function automatic vec_res_t predict_vector(input vec_cmd_t c);
        vec_res_t r;
        bit sat;
        longint m, x, y, nx, ny, ox, oy, om;
        logic [23:0] a, oa;
        logic [31:0] z, zr;
        sat = 1'b0;
        ox = 0;
        oy = 0;
        om = 0;
        oa = '0;
        r.status = ST_OK;
        if (c.command == CMD_POLAR_TO_RECT || c.command == CMD_ROTATE)
        begin
            m = longint'(c.in_first);
            a = c.in_second;
            if (m < 0)
            begin
                m = 0;
                sat = 1'b1;
            end
            if (m > MAG_MAX)
                m = MAG_MAX;
            if (c.command == CMD_ROTATE)
                a = a + c.delta_angle;
            cordic_rotate(m, {a, 8'h00}, ox, oy);
            ox = sat_coord(ox, sat);
            oy = sat_coord(oy, sat);
            om = m;
            oa = a;
        end
        else
        begin
            x = sat_coord(longint'(c.in_first), sat);
            y = longint'(c.in_second);
            if (c.command == CMD_OPPOSITE)
            begin
                nx = -x;
                ny = -y;
                x = sat_coord(nx, sat);
                y = sat_coord(ny, sat);
            end
            else if (c.command == CMD_ORTHOGONAL)
            begin
                nx = -y;
                ny = x;
                x = sat_coord(nx, sat);
                y = sat_coord(ny, sat);
            end
            if (c.command == CMD_UNIT)
            begin
                if (x == 0 && y == 0)
                    r.status = ST_ZERO;
                else
                begin
                    cordic_vector(x, y, m, z);
                    cordic_rotate(UNIT_ONE, z, ox, oy);
                    ox = sat_coord(ox, sat);
                    oy = sat_coord(oy, sat);
                    om = UNIT_ONE;
                    zr = z + 32'h80;
                    oa = zr[31:8];
                end
            end
            else
            begin
                cordic_vector(x, y, om, z);
                ox = x;
                oy = y;
                zr = z + 32'h80;
                oa = zr[31:8];
            end
        end
        if (r.status == ST_OK && sat)
            r.status = ST_SAT;
        r.out_x = ox[23:0];
        r.out_y = oy[23:0];
        r.out_magnitude = om[23:0];
        r.out_angle = oa;
        return r;
    endfunction

    function automatic logic signed [24:0] rand_first();
        case ($urandom_range(0, 5))
            0: return 25'(longint'($urandom_range(0, 16)) - 8);
            1: return 25'(longint'($urandom_range(0, 131072)) - 65536);
            2: return 25'(longint'($urandom_range(11863283 - 200, 11863283)));
            3: return 25'(longint'($urandom_range(0, 200)) - 8388608);
            default: return 25'(longint'($urandom_range(0, 20251891)) - 8388608);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_second();
        case ($urandom_range(0, 4))
            0: return 24'(longint'($urandom_range(0, 16)) - 8);
            1: return 24'(longint'($urandom_range(0, 131072)) - 65536);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic add_cmd(input cmd_t op, input longint f, input longint s,
                           input longint d);
        vec_cmd_t c;
        c.command = op;
        c.in_first = 25'(f);
        c.in_second = 24'(s);
        c.delta_angle = 24'(d);
        pending_cmds.push_back(c);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_transfers == issued)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 150 && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(1, 17) - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                in_ch.data <= pending_cmds.pop_front();
                in_ch.valid <= 1'b1;
                issued <= issued + 1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!hold_done && in_transfers >= 300)
        begin
            hold_done <= 1'b1;
            hold_count <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (pending_cmds.size() > 150 && $urandom_range(0, 9) == 0)
        begin
            recv_gap <= $urandom_range(1, 17) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        vec_res_t exp_r;
        vec_res_t act_r;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(predict_vector(in_ch.data));
                in_transfers <= in_transfers + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                act_r = out_ch.data;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transfer on output");
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (act_r.out_x !== exp_r.out_x)
                    begin
                        $error("out_x exp %0d got %0d", exp_r.out_x, act_r.out_x);
                        errors++;
                    end
                    if (act_r.out_y !== exp_r.out_y)
                    begin
                        $error("out_y exp %0d got %0d", exp_r.out_y, act_r.out_y);
                        errors++;
                    end
                    if (act_r.out_magnitude !== exp_r.out_magnitude)
                    begin
                        $error("out_magnitude exp %0d got %0d",
                               exp_r.out_magnitude, act_r.out_magnitude);
                        errors++;
                    end
                    if (act_r.out_angle !== exp_r.out_angle)
                    begin
                        $error("out_angle exp %0d got %0d", exp_r.out_angle, act_r.out_angle);
                        errors++;
                    end
                    if (act_r.status !== exp_r.status)
                    begin
                        $error("status exp %0d got %0d", exp_r.status, act_r.status);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        cmd_t op;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        in_transfers = 0;
        issued = 0;
        errors = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_count = 0;
        hold_done = 1'b0;
        idle_cycles = 0;

        add_cmd(CMD_RECT_TO_POLAR, 0, 0, 0);
        add_cmd(CMD_RECT_TO_POLAR, 11863283, 8388607, 0);
        add_cmd(CMD_RECT_TO_POLAR, -8388608, -8388608, 0);
        add_cmd(CMD_RECT_TO_POLAR, 65536, 0, 0);
        add_cmd(CMD_RECT_TO_POLAR, -65536, 1, 0);
        add_cmd(CMD_POLAR_TO_RECT, 11863283, 8388607, 0);
        add_cmd(CMD_POLAR_TO_RECT, -8388608, 4194304, 0);
        add_cmd(CMD_POLAR_TO_RECT, 65536, -8388608, 0);
        add_cmd(CMD_POLAR_TO_RECT, 0, 0, 0);
        add_cmd(CMD_ROTATE, 65536, 8388607, 8388607);
        add_cmd(CMD_ROTATE, 11863283, -8388608, -8388608);
        add_cmd(CMD_ROTATE, -1, 0, 2097152);
        add_cmd(CMD_OPPOSITE, -8388608, -8388608, 0);
        add_cmd(CMD_OPPOSITE, 8388607, 8388607, 0);
        add_cmd(CMD_OPPOSITE, 0, 0, 0);
        add_cmd(CMD_ORTHOGONAL, 11863283, -8388608, 0);
        add_cmd(CMD_ORTHOGONAL, -8388608, 8388607, 0);
        add_cmd(CMD_ORTHOGONAL, 65536, 65536, 0);
        add_cmd(CMD_UNIT, 0, 0, 0);
        add_cmd(CMD_UNIT, 1, 0, 0);
        add_cmd(CMD_UNIT, 11863283, 8388607, 0);
        add_cmd(CMD_UNIT, -8388608, -1, 0);
        add_cmd(CMD_UNIT, 0, -8388608, 0);
        for (int n = 0; n < 950; n++)
        begin
            op = cmd_t'($urandom_range(0, 5));
            if (op == CMD_UNIT && $urandom_range(0, 9) == 0)
                add_cmd(op, 0, 0, 24'($urandom()));
            else
                add_cmd(op, longint'(rand_first()), longint'(rand_second()),
                        longint'($signed(24'($urandom()))));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_cmds.size() == 0 && in_transfers == issued);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/vpr_pkg.sv
hdl/vpr_stream_if.sv
hdl/vpr_cordic.sv
hdl/vector_polar_rect_converter_unit.sv
hdl/vpr_checker.sv
tb/vector_polar_rect_converter_unit_test.sv
